FILE: hw/rtl/bounded_link_table_core_macros.svh
// Assertion macros shared by the link table RTL.
// Every macro samples on i_clk and is held off while i_rst_n is low.
`ifndef BOUNDED_LINK_TABLE_CORE_MACROS_SVH
`define BOUNDED_LINK_TABLE_CORE_MACROS_SVH

// Same-cycle implication: when cond holds, prop must hold too.
`define BLT_ASSERT_IMP(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication: when cond holds, prop must hold in the next cycle.
`define BLT_ASSERT_NXT(name, cond, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/blt_pkg.sv
// Package for the link table: field widths, command codes and the
// controller/datapath interface structs. No dependencies.
`default_nettype none

package blt_pkg;

    localparam int CMD_W      = 3;
    localparam int NODE_W     = 10;
    localparam int SLOT_W     = 3;
    localparam int LCNT_W     = 4;
    localparam int NODE_LIM   = 2 ** NODE_W;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;
    localparam int OUT_PAD_W  = OUT_DATA_W - LCNT_W - 2;

    localparam logic [LCNT_W-1:0] LCNT_MAX = '1;

    // Command codes carried on the input tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD2   = 3'd0,
        CMD_ADD1   = 3'd1,
        CMD_RMPAIR = 3'd2,
        CMD_RMSLOT = 3'd3,
        CMD_RMNODE = 3'd4,
        CMD_QUERY  = 3'd5,
        CMD_CLEAR  = 3'd6
    } t_cmd;

    // Which node owns the list being walked
    typedef enum logic [1:0] {
        OWN_A = 2'd0,
        OWN_B = 2'd1,
        OWN_P = 2'd2
    } t_own;

    // Controller to datapath
    typedef struct packed {
        logic load;
        t_own own_sel;
        logic cnt_rd;
        logic cnt_lat;
        logic st_rd;
        logic st_rd_next;
        logic mark_found;
        logic idx_inc;
        logic append;
        logic shift_wr;
        logic dec;
        logic node_rd;
        logic n_lat;
        logic j_inc;
        logic pt_lat;
        logic zero_a;
        logic clr_wr;
        logic set_conn;
        logic fail;
        logic fin;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic req_ok;
        logic found;
        logic full;
        logic idx_end;
        logic shift_end;
        logic slot_bad;
        logic match;
        logic j_end;
        logic pt_ok;
        logic clr_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/blt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module blt_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/blt_ctrl.sv
// Sequencing state machine of the link table.
// Depends on blt_pkg; drives blt_dp through t_dp_cmd, reads t_dp_sts.
`default_nettype none

module blt_ctrl
    import blt_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    typedef enum logic [20:0] {
        S_IDLE     = 21'h000001,
        S_DISP     = 21'h000002,
        S_CLR      = 21'h000004,
        S_CNT_RD   = 21'h000008,
        S_CNT_WT   = 21'h000010,
        S_SCAN_RD  = 21'h000020,
        S_SCAN_CMP = 21'h000040,
        S_DECIDE   = 21'h000080,
        S_APPEND   = 21'h000100,
        S_SHIFT_RD = 21'h000200,
        S_SHIFT_WR = 21'h000400,
        S_DEC      = 21'h000800,
        S_NEXT     = 21'h001000,
        S_NCNT_RD  = 21'h002000,
        S_NCNT_WT  = 21'h004000,
        S_NODE_RD  = 21'h008000,
        S_NODE_WT  = 21'h010000,
        S_NODE_CHK = 21'h020000,
        S_ZERO     = 21'h040000,
        S_FIN_RD   = 21'h080000,
        S_FIN_WT   = 21'h100000
    } t_state;

    t_state r_state, n_state;
    logic   r_pass,  n_pass;   // second direction of a pair command
    logic   r_init,  n_init;   // clearing pass after reset
    t_own   own;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_pass  <= 1'b0;
            r_init  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_init  <= n_init;
        end
    end

    // list owner: node_a for count reads of the item, the partner during
    // node removal, otherwise a or b by direction
    always_comb begin
        if (r_state == S_FIN_RD || r_state == S_NCNT_RD) begin
            own = OWN_A;
        end else if (i_sts.cmd == CMD_RMNODE) begin
            own = OWN_P;
        end else if (r_pass) begin
            own = OWN_B;
        end else begin
            own = OWN_A;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state       = r_state;
        n_pass        = r_pass;
        n_init        = r_init;
        o_in_ready    = 1'b0;
        o_cmd         = '0;
        o_cmd.own_sel = own;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_pass = 1'b0;
                if (i_sts.cmd == CMD_CLEAR) begin
                    n_state = S_CLR;
                end else if (!i_sts.req_ok) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_FIN_RD;
                end else if (i_sts.cmd == CMD_RMNODE) begin
                    n_state = S_NCNT_RD;
                end else begin
                    n_state = S_CNT_RD;
                end
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_init  = 1'b0;
                    n_state = r_init ? S_IDLE : S_FIN_RD;
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WT;
            end
            S_CNT_WT: begin
                o_cmd.cnt_lat = 1'b1;
                n_state       = (i_sts.cmd == CMD_RMSLOT) ? S_DECIDE : S_SCAN_RD;
            end
            S_SCAN_RD: begin
                if (i_sts.idx_end) begin
                    n_state = S_DECIDE;
                end else begin
                    o_cmd.st_rd = 1'b1;
                    n_state     = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_sts.match) begin
                    o_cmd.mark_found = 1'b1;
                    n_state          = S_DECIDE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SCAN_RD;
                end
            end
            S_DECIDE: begin
                unique case (i_sts.cmd) inside
                    CMD_RMSLOT: begin
                        if (i_sts.slot_bad) begin
                            o_cmd.fail = 1'b1;
                            n_state    = S_FIN_RD;
                        end else begin
                            n_state = S_SHIFT_RD;
                        end
                    end
                    CMD_ADD2, CMD_ADD1: begin
                        if (i_sts.found) begin
                            n_state = S_NEXT;
                        end else if (i_sts.full) begin
                            o_cmd.fail = 1'b1;
                            n_state    = S_NEXT;
                        end else begin
                            n_state = S_APPEND;
                        end
                    end
                    CMD_RMPAIR, CMD_RMNODE: begin
                        n_state = i_sts.found ? S_SHIFT_RD : S_NEXT;
                    end
                    CMD_QUERY: begin
                        o_cmd.set_conn = 1'b1;
                        n_state        = S_NEXT;
                    end
                    default: begin
                        n_state = S_FIN_RD;
                    end
                endcase
            end
            S_APPEND: begin
                o_cmd.append = 1'b1;
                n_state      = S_NEXT;
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_end) begin
                    n_state = S_DEC;
                end else begin
                    o_cmd.st_rd_next = 1'b1;
                    n_state          = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                n_state        = S_SHIFT_RD;
            end
            S_DEC: begin
                o_cmd.dec = 1'b1;
                n_state   = (i_sts.cmd == CMD_RMSLOT) ? S_FIN_RD : S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.cmd == CMD_RMNODE) begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_NODE_RD;
                end else if (!r_pass && (i_sts.cmd == CMD_ADD2 ||
                                         i_sts.cmd == CMD_RMPAIR ||
                                         i_sts.cmd == CMD_QUERY)) begin
                    n_pass  = 1'b1;
                    n_state = S_CNT_RD;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_NCNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_NCNT_WT;
            end
            S_NCNT_WT: begin
                o_cmd.n_lat = 1'b1;
                n_state     = S_NODE_RD;
            end
            S_NODE_RD: begin
                if (i_sts.j_end) begin
                    n_state = S_ZERO;
                end else begin
                    o_cmd.node_rd = 1'b1;
                    n_state       = S_NODE_WT;
                end
            end
            S_NODE_WT: begin
                o_cmd.pt_lat = 1'b1;
                n_state      = S_NODE_CHK;
            end
            S_NODE_CHK: begin
                if (i_sts.pt_ok) begin
                    n_state = S_CNT_RD;
                end else begin
                    o_cmd.j_inc = 1'b1;
                    n_state     = S_NODE_RD;
                end
            end
            S_ZERO: begin
                o_cmd.zero_a = 1'b1;
                n_state      = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_FIN_WT;
            end
            S_FIN_WT: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/blt_dp.sv
// Datapath of the link table: item registers, list walk counters, the
// link store and count memories, and the result register.
// Depends on blt_pkg, blt_ram and bounded_link_table_core_macros.svh.
`default_nettype none

`include "bounded_link_table_core_macros.svh"

module blt_dp
    import blt_pkg::*;
#(
    parameter int NODES     = 1024,
    parameter int MAX_LINKS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [CMD_W-1:0]  i_in_cmd,
    input  wire logic [NODE_W-1:0] i_in_node_a,
    input  wire logic [NODE_W-1:0] i_in_node_b,
    input  wire logic [SLOT_W-1:0] i_in_slot,
    input  wire t_dp_cmd           i_ctl,
    output t_dp_sts                o_sts,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic                   o_out_ok,
    output logic                   o_out_connected,
    output logic [LCNT_W-1:0]      o_out_link_count
);

    localparam int NODES_EFF = (NODES < NODE_LIM) ? NODES : NODE_LIM;
    localparam int NAW       = (NODES_EFF > 1) ? $clog2(NODES_EFF) : 1;
    localparam int LW        = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
    localparam int CW        = $clog2(MAX_LINKS + 1);
    localparam int ST_DEPTH  = NODES_EFF * (2 ** LW);

    // item registers
    logic [CMD_W-1:0]  r_cmd;
    logic [NODE_W-1:0] r_a, r_b, r_pt;
    logic [SLOT_W-1:0] r_slot;
    // list walk
    logic [CW-1:0]     r_own_cnt, r_idx, r_n, r_j;
    logic              r_found, r_ok, r_conn;
    logic [NAW-1:0]    r_clr_addr;
    // result register
    logic              r_out_valid, r_out_ok, r_out_conn;
    logic [LCNT_W-1:0] r_out_lc;

    logic [NODE_W-1:0] own_node, partner, st_rdata, st_wdata;
    logic [CW-1:0]     cnt_rdata, cnt_wdata, idx_nxt;
    logic [CW:0]       idx_p1;
    logic [NAW-1:0]    cnt_waddr;
    logic [NAW+LW-1:0] st_raddr, st_waddr;
    logic              cnt_we, st_we, st_re;
    logic              a_ok, b_ok, uses_b, known;
    logic [7:0]        cnt8;
    logic [LCNT_W-1:0] lc_sat;

    // owner and partner of the list being walked
    always_comb begin
        case (i_ctl.own_sel)
            OWN_A: begin
                own_node = r_a;
                partner  = r_b;
            end
            OWN_B: begin
                own_node = r_b;
                partner  = r_a;
            end
            OWN_P: begin
                own_node = r_pt;
                partner  = r_a;
            end
            default: begin
                own_node = r_a;
                partner  = r_b;
            end
        endcase
    end

    assign idx_nxt = r_idx + CW'(1);
    assign idx_p1  = {1'b0, r_idx} + (CW+1)'(1);

    // count memory: clear sweep, zeroing, append and decrement writes
    assign cnt_we    = i_ctl.clr_wr | i_ctl.zero_a | i_ctl.append | i_ctl.dec;
    assign cnt_waddr = i_ctl.clr_wr ? r_clr_addr :
                       (i_ctl.zero_a ? r_a[NAW-1:0] : own_node[NAW-1:0]);
    assign cnt_wdata = i_ctl.append ? (r_own_cnt + CW'(1)) :
                       (i_ctl.dec ? (r_own_cnt - CW'(1)) : '0);

    blt_ram #(
        .WIDTH (CW),
        .DEPTH (NODES_EFF)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_waddr),
        .i_wdata (cnt_wdata),
        .i_re    (i_ctl.cnt_rd),
        .i_raddr (own_node[NAW-1:0]),
        .o_rdata (cnt_rdata)
    );

    // link store: append at the count, shift-down copies entry idx+1 to idx
    assign st_we    = i_ctl.append | i_ctl.shift_wr;
    assign st_waddr = {own_node[NAW-1:0],
                       (i_ctl.append ? r_own_cnt[LW-1:0] : r_idx[LW-1:0])};
    assign st_wdata = i_ctl.append ? partner : st_rdata;
    assign st_re    = i_ctl.st_rd | i_ctl.st_rd_next | i_ctl.node_rd;
    assign st_raddr = i_ctl.node_rd    ? {r_a[NAW-1:0], r_j[LW-1:0]} :
                      i_ctl.st_rd_next ? {own_node[NAW-1:0], idx_nxt[LW-1:0]} :
                                         {own_node[NAW-1:0], r_idx[LW-1:0]};

    blt_ram #(
        .WIDTH (NODE_W),
        .DEPTH (ST_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (st_wdata),
        .i_re    (st_re),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    // request checks
    assign a_ok   = 32'(r_a) < 32'(NODES);
    assign b_ok   = 32'(r_b) < 32'(NODES);
    assign uses_b = (r_cmd == CMD_ADD2) || (r_cmd == CMD_ADD1) ||
                    (r_cmd == CMD_RMPAIR) || (r_cmd == CMD_QUERY);
    assign known  = uses_b || (r_cmd == CMD_RMSLOT) || (r_cmd == CMD_RMNODE);

    // status to the controller
    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.req_ok    = known && a_ok && (!uses_b || b_ok);
        o_sts.found     = r_found;
        o_sts.full      = r_own_cnt >= CW'(MAX_LINKS);
        o_sts.idx_end   = r_idx == r_own_cnt;
        o_sts.shift_end = idx_p1 >= {1'b0, r_own_cnt};
        o_sts.slot_bad  = 8'(r_slot) >= 8'(r_own_cnt);
        o_sts.match     = st_rdata == partner;
        o_sts.j_end     = r_j == r_n;
        o_sts.pt_ok     = (32'(r_pt) < 32'(NODES)) && (r_pt != r_a);
        o_sts.clr_last  = r_clr_addr == NAW'(NODES_EFF - 1);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    // item and walk registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_in_cmd;
            r_a    <= i_in_node_a;
            r_b    <= i_in_node_b;
            r_slot <= i_in_slot;
            r_ok   <= 1'b1;
            r_conn <= 1'b0;
        end
        if (i_ctl.fail) begin
            r_ok <= 1'b0;
        end
        if (i_ctl.set_conn) begin
            r_conn <= r_conn | r_found;
        end
        if (i_ctl.cnt_lat) begin
            r_own_cnt <= cnt_rdata;
            r_idx     <= (r_cmd == CMD_RMSLOT) ? CW'(r_slot) : '0;
            r_found   <= 1'b0;
        end else if (i_ctl.idx_inc) begin
            r_idx <= idx_nxt;
        end
        if (i_ctl.mark_found) begin
            r_found <= 1'b1;
        end
        if (i_ctl.n_lat) begin
            r_n <= cnt_rdata;
            r_j <= '0;
        end else if (i_ctl.j_inc) begin
            r_j <= r_j + CW'(1);
        end
        if (i_ctl.pt_lat) begin
            r_pt <= st_rdata;
        end
    end

    // clear sweep address, back to zero after the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_ctl.clr_wr) begin
            r_clr_addr <= o_sts.clr_last ? '0 : (r_clr_addr + NAW'(1));
        end
    end

    // link count saturates at the field maximum
    assign cnt8   = 8'(cnt_rdata);
    assign lc_sat = (cnt8 > 8'(LCNT_MAX)) ? LCNT_MAX : cnt8[LCNT_W-1:0];

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.fin) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            r_out_ok   <= r_ok;
            r_out_conn <= r_conn;
            r_out_lc   <= (a_ok && (r_cmd != CMD_CLEAR)) ? lc_sat : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_ok         = r_out_ok;
    assign o_out_connected  = r_out_conn;
    assign o_out_link_count = r_out_lc;

    `BLT_ASSERT_IMP(a_append_room, i_ctl.append, r_own_cnt < CW'(MAX_LINKS), "append to full list")
    `BLT_ASSERT_IMP(a_dec_nonzero, i_ctl.dec, r_own_cnt != '0, "decrement of empty list")
    `BLT_ASSERT_IMP(a_fin_free, i_ctl.fin, !r_out_valid || i_out_ready, "result overrun")
    `BLT_ASSERT_NXT(a_fin_shown, i_ctl.fin, r_out_valid, "result not presented")

endmodule

`default_nettype wire

FILE: hw/rtl/bounded_link_table_core.sv
// Top level of the bounded link table: stream ports, controller, datapath.
// Depends on blt_pkg, blt_ctrl and blt_dp.
`default_nettype none

// Each node keeps an ordered list of up to MAX_LINKS partners in an on-chip
// memory; every input transfer is one command and yields exactly one result
// transfer. Commands are handled one at a time by a state machine over a
// count memory and a link store, each with one write port and one registered
// read port. Most commands walk one list, or two for pair commands, scanning
// or shifting its entries. A remove-slot walks node_a's list without a scan.
// Node removal walks node_a's list and, for each partner in it, that
// partner's list. Clear-all sweeps all min(NODES, 1024) entries of the count
// memory, one entry a cycle. The next command can be accepted in the same
// cycle that the result is offered. After reset the same sweep runs with
// s_axis_tready low. A finished result sits in an output register, and the
// next command is taken while it waits.
module bounded_link_table_core
    import blt_pkg::*;
#(
    parameter int NODES     = 1024,
    parameter int MAX_LINKS = 8
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // [9:0] node_a, [19:10] node_b, [22:20] slot, [23] zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] cmd
    input  wire logic [CMD_W-1:0]      i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // [0] ok, [1] connected, [5:2] link_count, [7:6] zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    t_dp_cmd           ctl;
    t_dp_sts           sts;
    logic              out_ok, out_conn;
    logic [LCNT_W-1:0] out_lc;

    blt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (ctl)
    );

    blt_dp #(
        .NODES     (NODES),
        .MAX_LINKS (MAX_LINKS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_cmd         (i_s_axis_tuser),
        .i_in_node_a      (i_s_axis_tdata[NODE_W-1:0]),
        .i_in_node_b      (i_s_axis_tdata[2*NODE_W-1:NODE_W]),
        .i_in_slot        (i_s_axis_tdata[2*NODE_W+SLOT_W-1:2*NODE_W]),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .o_out_valid      (o_m_axis_tvalid),
        .i_out_ready      (i_m_axis_tready),
        .o_out_ok         (out_ok),
        .o_out_connected  (out_conn),
        .o_out_link_count (out_lc)
    );

    // result packing, lowest field first
    assign o_m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_lc, out_conn, out_ok};

endmodule

`default_nettype wire

FILE: tb/tb_bounded_link_table_core.sv
// Self-checking testbench for bounded_link_table_core: directed and random commands
// on the input stream, each result transfer checked against an in-bench link table model.
// Depends on blt_pkg and the bounded_link_table_core RTL.
`default_nettype none

module tb_bounded_link_table_core;
    import blt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_TB     = 1024;
    localparam int LINKS        = 8;
    localparam int RANDOM_ITEMS = 1525;
    localparam int POOL_SIZE    = 10;
    localparam int SINK_HOLD    = 400;
    localparam int STALL_LIMIT  = 8000;
    localparam int PRINT_LIMIT  = 100;

    // Command code the block must reject
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    // One expected result, with the command that caused it for messages
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        int                a;
        int                b;
        logic              ok;
        logic              conn;
        logic [LCNT_W-1:0] cnt;
    } t_link_result;

    // Link table model and queue of results still owed by the block
    class t_link_scoreboard;
        logic [NODE_W-1:0] partners [NODES_TB][LINKS];
        int                fill [NODES_TB];
        t_link_result      pending_results [$];
        int                errors;

        function new();
            foreach (fill[i]) fill[i] = 0;
            errors = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT) $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function int locate(int owner, int partner);
            for (int i = 0; i < fill[owner]; i++)
                if (partners[owner][i] == partner) return i;
            return -1;
        endfunction

        // Append unless already present; fails only on a full list
        function bit append_partner(int owner, int partner);
            if (locate(owner, partner) >= 0) return 1'b1;
            if (fill[owner] >= LINKS) return 1'b0;
            partners[owner][fill[owner]] = partner[NODE_W-1:0];
            fill[owner]++;
            return 1'b1;
        endfunction

        // Delete one entry, later entries move down
        function bit delete_entry(int owner, int pos);
            if (pos >= fill[owner]) return 1'b0;
            for (int i = pos; i + 1 < fill[owner]; i++)
                partners[owner][i] = partners[owner][i+1];
            fill[owner]--;
            return 1'b1;
        endfunction

        function void unlink(int owner, int partner);
            int k;
            k = locate(owner, partner);
            if (k >= 0) void'(delete_entry(owner, k));
        endfunction

        function t_link_result apply_command(logic [CMD_W-1:0] cmd, int a, int b, int sl);
            t_link_result      r;
            bit                uses_b;
            bit                r1;
            bit                r2;
            int                n;
            logic [NODE_W-1:0] snap [LINKS];
            r.cmd  = cmd;
            r.a    = a;
            r.b    = b;
            r.ok   = 1'b0;
            r.conn = 1'b0;
            uses_b = (cmd == CMD_ADD2 || cmd == CMD_ADD1 || cmd == CMD_RMPAIR ||
                      cmd == CMD_QUERY);
            if (cmd == CMD_CLEAR) begin
                foreach (fill[i]) fill[i] = 0;
                r.ok = 1'b1;
            end else if (cmd != CMD_UNUSED && a < NODES_TB && (!uses_b || b < NODES_TB)) begin
                case (cmd)
                    CMD_ADD2: begin
                        r1   = append_partner(a, b);
                        r2   = append_partner(b, a);
                        r.ok = r1 && r2;
                    end
                    CMD_ADD1: begin
                        r.ok = append_partner(a, b);
                    end
                    CMD_RMPAIR: begin
                        unlink(a, b);
                        unlink(b, a);
                        r.ok = 1'b1;
                    end
                    CMD_RMSLOT: begin
                        r.ok = delete_entry(a, sl);
                    end
                    CMD_RMNODE: begin
                        // snapshot first so shifting lists never skips a partner
                        n = fill[a];
                        for (int i = 0; i < n; i++) snap[i] = partners[a][i];
                        for (int i = 0; i < n; i++)
                            if (snap[i] != a) unlink(int'(snap[i]), a);
                        fill[a] = 0;
                        r.ok    = 1'b1;
                    end
                    default: begin
                        r.conn = (locate(a, b) >= 0) || (locate(b, a) >= 0);
                        r.ok   = 1'b1;
                    end
                endcase
            end
            n     = (a < NODES_TB && cmd != CMD_CLEAR) ? fill[a] : 0;
            r.cnt = (n > 15) ? LCNT_MAX : n[LCNT_W-1:0];
            return r;
        endfunction

        function void note_command(logic [CMD_W-1:0] cmd, int a, int b, int sl);
            pending_results.push_back(apply_command(cmd, a, b, sl));
        endfunction

        task check_result(logic [OUT_DATA_W-1:0] data);
            t_link_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result %02h with no command outstanding", data));
                return;
            end
            want = pending_results.pop_front();
            if (data[0] !== want.ok)
                report($sformatf("cmd %0d a=%0d b=%0d: ok %b, want %b",
                                 want.cmd, want.a, want.b, data[0], want.ok));
            if (data[1] !== want.conn)
                report($sformatf("cmd %0d a=%0d b=%0d: connected %b, want %b",
                                 want.cmd, want.a, want.b, data[1], want.conn));
            if (data[5:2] !== want.cnt)
                report($sformatf("cmd %0d a=%0d b=%0d: link_count %0d, want %0d",
                                 want.cmd, want.a, want.b, data[5:2], want.cnt));
        endtask
    endclass

    logic                  i_clk    = 1'b0;
    logic                  i_rst_n  = 1'b0;
    logic                  s_valid  = 1'b0;
    logic [IN_DATA_W-1:0]  s_data   = '0;
    logic [CMD_W-1:0]      s_user   = '0;
    logic                  m_ready  = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    bit                    hold_sink = 1'b0;
    bit                    steady    = 1'b0;
    int                    stall_cycles = 0;
    int                    node_pool [POOL_SIZE];
    t_link_scoreboard      sb;

    bounded_link_table_core #(
        .NODES     (NODES_TB),
        .MAX_LINKS (LINKS)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CMD_W-1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28) return CMD_ADD2;
        if (r < 46) return CMD_ADD1;
        if (r < 56) return CMD_RMPAIR;
        if (r < 66) return CMD_RMSLOT;
        if (r < 72) return CMD_RMNODE;
        if (r < 94) return CMD_QUERY;
        if (r < 97) return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    // A small pool keeps lists busy and full; the rest spans the whole range
    function automatic int pick_node();
        if ($urandom_range(0, 99) < 85) return node_pool[$urandom_range(0, POOL_SIZE-1)];
        return $urandom_range(0, NODES_TB-1);
    endfunction

    function automatic void refresh_pool();
        foreach (node_pool[i]) node_pool[i] = $urandom_range(0, NODES_TB-1);
    endfunction

    // Offer one command and hold it until the transfer happens
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int a, input int b,
                            input int sl);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= {1'b0, sl[SLOT_W-1:0], b[NODE_W-1:0], a[NODE_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Sender pauses until every owed result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
    endtask

    // Result side ready pattern, with one long hold-off on request
    initial begin : result_sink
        int gap;
        forever begin
            if (hold_sink) begin
                m_ready <= 1'b0;
                repeat (SINK_HOLD) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // Monitor both streams; each transfer is noted or checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && o_s_axis_tready)
                sb.note_command(s_user, s_data[9:0], s_data[19:10], s_data[22:20]);
            if (o_m_axis_tvalid && m_ready)
                sb.check_result(o_m_axis_tdata);
        end
    end

    // Watchdog: too long with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && o_s_axis_tready) || (o_m_axis_tvalid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("bounded_link_table_core test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : stimulus
        sb = new();
        refresh_pool();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, full list, duplicates, self link, every command
        send_cmd(CMD_QUERY, 0, 1023, 0);
        send_cmd(CMD_ADD2, 0, 1023, 7);
        send_cmd(CMD_ADD2, 5, 5, 0);
        for (int i = 1; i <= 7; i++) send_cmd(CMD_ADD1, 0, i, 0);
        send_cmd(CMD_ADD1, 0, 9, 0);          // list full
        send_cmd(CMD_ADD2, 0, 1023, 0);       // already linked
        send_cmd(CMD_ADD2, 3, 0, 0);          // one direction full
        send_cmd(CMD_QUERY, 1023, 0, 0);
        send_cmd(CMD_QUERY, 1, 0, 0);         // only the reverse direction exists
        send_cmd(CMD_RMSLOT, 0, 0, 7);
        send_cmd(CMD_RMSLOT, 0, 0, 7);        // slot past the count
        send_cmd(CMD_RMSLOT, 0, 0, 0);
        send_cmd(CMD_RMPAIR, 0, 1023, 0);
        send_cmd(CMD_RMPAIR, 0, 1023, 0);     // no such link
        send_cmd(CMD_RMNODE, 0, 0, 0);
        send_cmd(CMD_RMNODE, 5, 0, 0);        // self link
        send_cmd(CMD_UNUSED, 3, 0, 0);
        send_cmd(CMD_CLEAR, 1023, 1023, 7);
        send_cmd(CMD_QUERY, 3, 0, 0);
        drain_results();

        // Random traffic with one long result hold-off and one full pause
        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 150 == 0) refresh_pool();
            if (k == 400) hold_sink = 1'b1;
            if (k == 800) drain_results();
            steady = (k >= 1000 && k < 1150);
            send_cmd(pick_cmd(), pick_node(), pick_node(), $urandom_range(0, 7));
        end
        drain_results();
        repeat (40) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("bounded_link_table_core test passed");
        else
            $display("bounded_link_table_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
